// ===== rtl/sidi_pkg.sv =====
`timescale 1ns / 1ps

package sidi_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int DigitWidth = 4;
  localparam int BcdWidth   = NumDigits * DigitWidth;
  localparam int CharWidth  = 6;
  localparam int ShiftCntW  = $clog2(ValueWidth);
  localparam int RemCntW    = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] AsciiZero  = CharWidth'(48);
  localparam logic [CharWidth-1:0] AsciiMinus = CharWidth'(45);
  localparam logic [CharWidth-1:0] AsciiNine  = CharWidth'(57);

  // Requests from the sequencer to the BCD converter.
  typedef struct packed {
    logic load;   // start a new conversion from the magnitude input
    logic pop;    // shift the BCD word up by one digit
  } dab_ctrl_t;

  // Status from the BCD converter back to the sequencer.
  typedef struct packed {
    logic                  busy;
    logic [DigitWidth-1:0] top_digit;
  } dab_sts_t;

endpackage

// ===== rtl/sidi_dabble.sv =====
`timescale 1ns / 1ps

module sidi_dabble (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sidi_pkg::dab_ctrl_t            ctrl,
  input  logic [sidi_pkg::ValueWidth-1:0] mag,
  output sidi_pkg::dab_sts_t             sts
);
  import sidi_pkg::*;

  logic [ValueWidth-1:0] mag_r;
  logic [BcdWidth-1:0]   bcd_r;
  logic [BcdWidth-1:0]   bcd_adj;
  logic [ShiftCntW-1:0]  cnt_r;
  logic                  busy_r;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_r[d*DigitWidth +: DigitWidth] >= DigitWidth'(5)) begin
        bcd_adj[d*DigitWidth +: DigitWidth] = bcd_r[d*DigitWidth +: DigitWidth] + DigitWidth'(3);
      end else begin
        bcd_adj[d*DigitWidth +: DigitWidth] = bcd_r[d*DigitWidth +: DigitWidth];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      mag_r  <= mag;
      bcd_r  <= '0;
    end else if (busy_r) begin
      bcd_r <= {bcd_adj[BcdWidth-2:0], mag_r[ValueWidth-1]};
      mag_r <= {mag_r[ValueWidth-2:0], 1'b0};
      cnt_r <= cnt_r + ShiftCntW'(1);
      if (cnt_r == ShiftCntW'(ValueWidth - 1)) begin
        busy_r <= 1'b0;
      end
    end else if (ctrl.pop) begin
      bcd_r <= {bcd_r[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
    end
  end

  assign sts.busy      = busy_r;
  assign sts.top_digit = bcd_r[BcdWidth-1 -: DigitWidth];

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text.
//
// The input channel (in_valid, in_ready, in_value) takes one signed word per
// conversion. The output channel (out_valid, out_ready, out_ascii_char,
// out_last) returns its decimal text one character per word, most significant
// first: a minus sign for negative values, then the digits without leading
// zeros. out_last marks the final character of each number.
//
// A conversion runs one value at a time. After the input word is taken, the
// magnitude is shifted bit by bit through a double-dabble BCD register, and
// the sequencer waits for the shift to finish. A negative value then emits
// its minus sign. Each of the ten digit positions is then stepped through in
// turn, whether it is a dropped leading zero or an emitted digit, so with no
// stalls an item takes the same time whatever its digit count, a negative
// value taking longer by its sign. in_ready is high only while no conversion
// is in progress.
//
// A stalled receiver simply holds the current character in the output
// register; the sequencer waits and nothing is lost. Synchronous reset
// (rst_n low) drops any conversion in flight and empties the output register.

module signed_int_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sidi_pkg::ValueWidth-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sidi_pkg::CharWidth-1:0]  out_ascii_char,
  output logic                            out_last
);
  import sidi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic                  neg_r;
  logic [RemCntW-1:0]    rem_r;
  logic                  out_valid_r;
  logic [CharWidth-1:0]  out_char_r;
  logic                  out_last_r;

  dab_ctrl_t             dab_ctrl;
  dab_sts_t              dab_sts;
  logic [ValueWidth-1:0] magnitude;
  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  // The output register can take a new character when it is empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  // A character is written into the output register in this cycle.
  assign out_load = ((state_r == ST_SIGN) || (state_r == ST_EMIT)) && out_free;

  // Two's complement magnitude; the most negative value maps to 2^31 unsigned.
  assign magnitude = in_value[ValueWidth-1] ? (~in_value + ValueWidth'(1)) : in_value;

  assign dab_ctrl.load = in_fire;
  // Digits are dropped while skipping leading zeros, or consumed as they are emitted.
  assign dab_ctrl.pop  = ((state_r == ST_SKIP) && (dab_sts.top_digit == '0)
                          && (rem_r > RemCntW'(1)))
                      || ((state_r == ST_EMIT) && out_free);

  sidi_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dab_ctrl),
    .mag   (magnitude),
    .sts   (dab_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            neg_r   <= in_value[ValueWidth-1];
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (!dab_sts.busy) begin
            rem_r   <= RemCntW'(NumDigits);
            state_r <= neg_r ? ST_SIGN : ST_SKIP;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_char_r  <= AsciiMinus;
            out_last_r  <= 1'b0;
            state_r     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // The final digit is always kept, so zero still gives one character.
          if ((dab_sts.top_digit == '0) && (rem_r > RemCntW'(1))) begin
            rem_r <= rem_r - RemCntW'(1);
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_char_r  <= AsciiZero + CharWidth'(dab_sts.top_digit);
            out_last_r  <= (rem_r == RemCntW'(1));
            rem_r       <= rem_r - RemCntW'(1);
            if (rem_r == RemCntW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last       = out_last_r;

  // A new value is never taken while the BCD shift is still running.
  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !dab_sts.busy)
    else $error("input accepted while conversion busy");

  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_char == AsciiMinus)
               || ((out_ascii_char >= AsciiZero) && (out_ascii_char <= AsciiNine)))
    else $error("output character out of range");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_ascii_char == AsciiMinus)) |-> !out_last)
    else $error("minus sign flagged as last");

  // Emitting always has at least one digit left to send.
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r != '0))
    else $error("emit with no digits remaining");

endmodule
